### rtl/bam_pkg.sv
`timescale 1ns / 1ps

package bam_pkg;

  // default sizes of the search
  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned ERR_LIMIT   = 3;

  // width of a code point
  localparam int unsigned CP_W = 21;

  // field widths at the default sizes
  localparam int unsigned DEF_IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned DEF_LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned DEF_ERR_W  = (ERR_LIMIT > 0) ? $clog2(ERR_LIMIT + 1) : 1;
  localparam int unsigned DEF_BEST_W = $clog2(ERR_LIMIT + 2);

  // item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

endpackage

### rtl/bam_in_if.sv
`timescale 1ns / 1ps

interface bam_in_if
  import bam_pkg::*;
#(
  parameter int unsigned IdxW = DEF_IDX_W
) ();

  logic            valid;
  logic            ready;
  logic            mode;
  logic [IdxW-1:0] pattern_index;
  logic [CP_W-1:0] code_point;
  logic            first_of_text;
  logic            last_of_text;

  modport source (
    output valid, mode, pattern_index, code_point, first_of_text, last_of_text,
    input  ready
  );

  modport sink (
    input  valid, mode, pattern_index, code_point, first_of_text, last_of_text,
    output ready
  );

endinterface

### rtl/bam_out_if.sv
`timescale 1ns / 1ps

interface bam_out_if
  import bam_pkg::*;
#(
  parameter int unsigned ErrW  = DEF_ERR_W,
  parameter int unsigned BestW = DEF_BEST_W
) ();

  logic             valid;
  logic             ready;
  logic             match_here;
  logic [ErrW-1:0]  error_count;
  logic [BestW-1:0] best_so_far;
  logic             end_of_text;

  modport source (
    output valid, match_here, error_count, best_so_far, end_of_text,
    input  ready
  );

  modport sink (
    input  valid, match_here, error_count, best_so_far, end_of_text,
    output ready
  );

endinterface

### rtl/bitap_approximate_match_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake     payload
// item_i    in         valid/ready   mode, pattern_index, code_point, first/last_of_text
// result_o  out        valid/ready   match_here, error_count, best_so_far, end_of_text
// cfg       in         cfg_we_i      cfg_data_i = pattern_length
//
// one transaction per cycle sustained, text items only while result_o is not stalled; a
// text item's result passes the input register, then the result register; a pattern load
// gives none. the whole level update is combinational from the input register, since the
// next text item needs the vectors this one leaves.
// rst_ni clears the vectors, best count and length (to 1); the pattern store is not reset.
// a stalled result holds the result register; one more item waits in the input register.

module bitap_approximate_match_top
  import bam_pkg::*;
#(
  parameter int unsigned MaxPattern = MAX_PATTERN,
  parameter int unsigned ErrLimit   = ERR_LIMIT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [$clog2(MaxPattern + 1)-1:0]   cfg_data_i,
  bam_in_if.sink                              item_i,
  bam_out_if.source                           result_o
);

  localparam int unsigned IdxW    = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned LenW    = $clog2(MaxPattern + 1);
  localparam int unsigned ErrW    = (ErrLimit > 0) ? $clog2(ErrLimit + 1) : 1;
  localparam int unsigned BestW   = $clog2(ErrLimit + 2);
  localparam int unsigned Levels  = ErrLimit + 1;
  localparam logic [BestW-1:0] NoMatch = BestW'(ErrLimit + 1);

  typedef logic [MaxPattern-1:0] vec_t;

  // configuration: length mask and last-position bit
  logic [LenW-1:0] len_used;
  vec_t            lm_q, lm_d;
  vec_t            top_q, top_d;

  always_comb begin
    if (cfg_data_i == '0) begin
      len_used = LenW'(1);
    end else if (int'(cfg_data_i) > int'(MaxPattern)) begin
      len_used = LenW'(MaxPattern);
    end else begin
      len_used = cfg_data_i;
    end
    for (int i = 0; i < int'(MaxPattern); i++) begin
      lm_d[i]  = (i < int'(len_used));
      top_d[i] = (i == int'(len_used) - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lm_q  <= vec_t'(1);
      top_q <= vec_t'(1);
    end else if (cfg_we_i) begin
      lm_q  <= lm_d;
      top_q <= top_d;
    end
  end

  // input register
  logic            s1_valid_q;
  logic            s1_mode_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [CP_W-1:0] s1_cp_q;
  logic            s1_first_q;
  logic            s1_last_q;

  logic res_valid_q;
  logic res_free;
  logic s1_adv;

  assign res_free     = !res_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && ((s1_mode_q == MODE_LOAD) || res_free);
  assign item_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_mode_q  <= item_i.mode;
      s1_idx_q   <= item_i.pattern_index;
      s1_cp_q    <= item_i.code_point;
      s1_first_q <= item_i.first_of_text;
      s1_last_q  <= item_i.last_of_text;
    end
  end

  // pattern store, compared at every position in parallel
  logic [CP_W-1:0] store_q [MaxPattern];

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_mode_q == MODE_LOAD) && (int'(s1_idx_q) < int'(MaxPattern))) begin
      store_q[s1_idx_q] <= s1_cp_q;
    end
  end

  // search state
  vec_t             lv_q [Levels];
  vec_t             lv_d [Levels];
  vec_t             prev_q;
  logic [BestW-1:0] best_q, best_d;

  vec_t             mm;
  vec_t             prev_cur;
  vec_t             old_v [Levels];
  vec_t             sh_old [Levels];
  vec_t             sh_prevnew;
  vec_t             tr_src;
  vec_t             sh_tr;
  vec_t             v;
  logic [BestW-1:0] best_cur;
  logic [BestW-1:0] found;

  always_comb begin
    sh_prevnew = '0;
    tr_src     = '0;
    sh_tr      = '0;
    v          = '0;
    for (int i = 0; i < int'(MaxPattern); i++) begin
      mm[i] = (store_q[i] == s1_cp_q) && lm_q[i];
    end

    // a new text starts from cleared vectors
    prev_cur = s1_first_q ? '0 : prev_q;
    best_cur = s1_first_q ? NoMatch : best_q;
    for (int d = 0; d < int'(Levels); d++) begin
      old_v[d]  = s1_first_q ? '0 : (lv_q[d] & lm_q);
      sh_old[d] = {old_v[d][MaxPattern-2:0], 1'b1} & lm_q;
    end

    lv_d[0] = sh_old[0] & mm;
    for (int d = 1; d < int'(Levels); d++) begin
      sh_prevnew = {lv_d[d-1][MaxPattern-2:0], 1'b1} & lm_q;
      v = (sh_old[d] & mm) | sh_old[d-1] | old_v[d-1] | sh_prevnew;
      // transposition term
      tr_src = mm & old_v[d];
      sh_tr  = {tr_src[MaxPattern-2:0], 1'b1} & lm_q;
      v = v | (prev_cur & sh_old[d] & sh_tr);
      lv_d[d] = v & lm_q;
    end

    found = NoMatch;
    for (int d = int'(Levels) - 1; d >= 0; d--) begin
      if ((lv_d[d] & top_q) != '0) begin
        found = BestW'(d);
      end
    end
    best_d = (found < best_cur) ? found : best_cur;
  end

  logic text_adv;
  assign text_adv = s1_adv && (s1_mode_q == MODE_TEXT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < int'(Levels); d++) begin
        lv_q[d] <= '0;
      end
      prev_q <= '0;
      best_q <= NoMatch;
    end else if (text_adv) begin
      for (int d = 0; d < int'(Levels); d++) begin
        lv_q[d] <= lv_d[d];
      end
      prev_q <= mm;
      best_q <= best_d;
    end
  end

  // result register
  logic             match_q;
  logic [ErrW-1:0]  err_q;
  logic [BestW-1:0] best_out_q;
  logic             eot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= text_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_adv) begin
      match_q    <= (found != NoMatch);
      err_q      <= (found != NoMatch) ? found[ErrW-1:0] : '0;
      best_out_q <= best_d;
      eot_q      <= s1_last_q;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.match_here  = match_q;
  assign result_o.error_count = err_q;
  assign result_o.best_so_far = best_out_q;
  assign result_o.end_of_text = eot_q;

endmodule
